/* hdl/swm_pkg.sv */
// Shared constants for the sliding window median core.
package swm_pkg;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int LEN_RESET       = 4;
endpackage

/* hdl/swm_if.sv */
// Request channels of the sliding window median core: samples, medians, window length.
interface swm_in_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_BITS:0] median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

interface swm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swm_pkg::CFG_BITS-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/swm_ram.sv */
// Simple dual-port RAM: one write and one registered read per cycle, read-first.
module swm_ram #(
    parameter int DEPTH = swm_pkg::WINDOW_MAX_DEF,
    parameter int WIDTH = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

/* hdl/sliding_window_median_core.sv */
// Top level of the sliding window running median filter.
//
// Channels: in_ch takes one signed sample plus a restart flag per request;
// out_ch gives twice the window median (one fractional bit, exact);
// cfg_ch writes the window length (0 acts as 1, above WINDOW_MAX saturates).
// A length write empties the window; it is taken only while idle, and in_ch
// is held off in any cycle where a length write is offered.
//
// Timing: one request at a time. Once the window is full, an item passes
// through the accept step, a forward pass over the sorted RAM to find and
// squeeze out the leaving sample, a backward pass that shifts in the new one
// (plus a write at the bottom when it is the smallest), then the reads of
// the middle entries. The single write and single read port of the sorted
// RAM set the pace. While filling, an item that does not complete the
// window gives no median; the item that completes it gives one.
// Reset: window length 4, window empty; RAM contents need no clearing.
// A median waits in the output register while out_ch stalls; the next input
// is taken and processed meanwhile and only holds when its own median is
// ready to load into a still-occupied output register.
module sliding_window_median_core #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swm_in_if.sink       in_ch,
    swm_out_if.source    out_ch,
    swm_cfg_if.sink      cfg_ch
);
    import swm_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int LEN_INIT = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REMOVE   = 3'd1;
    localparam logic [2:0] S_INSERT   = 3'd2;
    localparam logic [2:0] S_INS_LAST = 3'd3;
    localparam logic [2:0] S_MED_A    = 3'd4;
    localparam logic [2:0] S_MED_B    = 3'd5;
    localparam logic [2:0] S_MED_C    = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [LEN_W-1:0]              r_len, n_len;        // effective window length
    logic [LEN_W-1:0]              r_fill, n_fill;
    logic [IDX_W-1:0]              r_ptr, n_ptr;        // oldest history slot
    logic signed [SAMPLE_BITS-1:0] r_samp, n_samp;
    logic                          r_emit, n_emit;
    logic [LEN_W-1:0]              r_ra, n_ra;          // sorted RAM read index
    logic                          r_stop, n_stop;      // insert pass issued its last read
    logic                          r_found, n_found;    // leaving value already located
    logic                          r_dval, n_dval;      // sorted RAM data valid this cycle
    logic [IDX_W-1:0]              r_didx, n_didx;      // index of that data
    logic signed [SAMPLE_BITS-1:0] r_m0, n_m0;
    logic                          r_ovalid, n_ovalid;
    logic signed [SAMPLE_BITS:0]   r_omed, n_omed;

    logic                          hist_we, hist_re;
    logic [IDX_W-1:0]              hist_wa, hist_ra;
    logic [SAMPLE_BITS-1:0]        hist_q;
    logic                          srt_we, srt_re;
    logic [IDX_W-1:0]              srt_wa, srt_ra;
    logic [SAMPLE_BITS-1:0]        srt_wd, srt_q_raw;
    logic signed [SAMPLE_BITS-1:0] srt_q, hist_old;

    logic                          in_acc, cfg_acc;
    logic [LEN_W-1:0]              fill_eff, cfg_len;
    logic [LEN_W-1:0]              half;
    logic [IDX_W-1:0]              ptr_inc;

    assign srt_q    = signed'(srt_q_raw);
    assign hist_old = signed'(hist_q);

    // a pending length write wins over a sample
    assign in_ch.ready    = (r_state == S_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready   = (r_state == S_IDLE);
    assign out_ch.valid   = r_ovalid;
    assign out_ch.median_doubled = r_omed;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

    assign fill_eff = in_ch.restart ? '0 : r_fill;
    assign half     = r_len >> 1;
    assign ptr_inc  = r_ptr + 1'b1;

    // clamp the written length into 1..WINDOW_MAX
    always_comb begin
        if (cfg_ch.data == '0) begin
            cfg_len = LEN_W'(1);
        end else if (32'(cfg_ch.data) > 32'(WINDOW_MAX)) begin
            cfg_len = LEN_W'(WINDOW_MAX);
        end else begin
            cfg_len = LEN_W'(cfg_ch.data);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_fill   = r_fill;
        n_ptr    = r_ptr;
        n_samp   = r_samp;
        n_emit   = r_emit;
        n_ra     = r_ra;
        n_stop   = r_stop;
        n_found  = r_found;
        n_dval   = 1'b0;
        n_didx   = r_didx;
        n_m0     = r_m0;
        n_ovalid = r_ovalid;
        n_omed   = r_omed;

        hist_we = 1'b0;
        hist_wa = r_ptr;
        hist_re = 1'b0;
        hist_ra = r_ptr;
        srt_we  = 1'b0;
        srt_wa  = '0;
        srt_wd  = r_samp;
        srt_re  = 1'b0;
        srt_ra  = r_ra[IDX_W-1:0];

        if (out_ch.valid && out_ch.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_len  = cfg_len;
                    n_fill = '0;
                    n_ptr  = '0;
                end else if (in_acc) begin
                    n_samp = in_ch.sample;
                    if (fill_eff >= r_len) begin
                        // full: fetch the leaving sample, overwrite its slot (read-first)
                        hist_re  = 1'b1;
                        hist_we  = 1'b1;
                        hist_wa  = r_ptr;
                        n_ptr    = (LEN_W'(ptr_inc) == r_len) ? '0 : ptr_inc;
                        n_fill   = r_len;
                        n_emit   = 1'b1;
                        n_ra     = '0;
                        n_found  = 1'b0;
                        n_state  = S_REMOVE;
                    end else begin
                        hist_we  = 1'b1;
                        hist_wa  = fill_eff[IDX_W-1:0];
                        n_fill   = fill_eff + 1'b1;
                        n_ptr    = '0;
                        n_emit   = ((fill_eff + 1'b1) >= r_len);
                        n_stop   = 1'b0;
                        if (fill_eff == '0) begin
                            n_state = S_INS_LAST;
                        end else begin
                            n_ra    = fill_eff - 1'b1;
                            n_state = S_INSERT;
                        end
                    end
                end
            end

            S_REMOVE: begin
                // forward scan; after the first match every entry moves down one
                if (r_ra < r_len) begin
                    srt_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                    n_dval = 1'b1;
                    n_didx = r_ra[IDX_W-1:0];
                end
                if (r_dval) begin
                    if (r_found) begin
                        srt_we = 1'b1;
                        srt_wa = r_didx - 1'b1;
                        srt_wd = srt_q;
                    end else if (srt_q == hist_old) begin
                        n_found = 1'b1;
                    end
                    if (LEN_W'(r_didx) == r_len - 1'b1) begin
                        n_dval = 1'b0;
                        n_stop = 1'b0;
                        if (r_len == LEN_W'(1)) begin
                            n_state = S_INS_LAST;
                        end else begin
                            n_ra    = r_len - LEN_W'(2);
                            n_state = S_INSERT;
                        end
                    end
                end
            end

            S_INSERT: begin
                // backward scan; larger entries move up until the slot is found
                if (!r_stop) begin
                    srt_re = 1'b1;
                    n_dval = 1'b1;
                    n_didx = r_ra[IDX_W-1:0];
                    if (r_ra == '0) begin
                        n_stop = 1'b1;
                    end else begin
                        n_ra = r_ra - 1'b1;
                    end
                end
                if (r_dval) begin
                    srt_we = 1'b1;
                    srt_wa = r_didx + 1'b1;
                    if (srt_q > r_samp) begin
                        srt_wd = srt_q;
                        if (r_didx == '0) begin
                            n_dval  = 1'b0;
                            n_state = S_INS_LAST;
                        end
                    end else begin
                        srt_wd  = r_samp;
                        n_dval  = 1'b0;
                        n_state = S_MED_A;
                    end
                end
            end

            S_INS_LAST: begin
                srt_we  = 1'b1;
                srt_wa  = '0;
                srt_wd  = r_samp;
                n_state = S_MED_A;
            end

            S_MED_A: begin
                if (!r_emit) begin
                    n_state = S_IDLE;
                end else begin
                    srt_re  = 1'b1;
                    srt_ra  = r_len[0] ? half[IDX_W-1:0] : IDX_W'(half - 1'b1);
                    n_state = S_MED_B;
                end
            end

            S_MED_B: begin
                n_m0    = srt_q;
                srt_re  = 1'b1;
                srt_ra  = half[IDX_W-1:0];
                n_state = S_MED_C;
            end

            S_MED_C: begin
                // hold until the output register is free
                if (!r_ovalid || out_ch.ready) begin
                    n_ovalid = 1'b1;
                    if (r_len[0]) begin
                        n_omed = {r_m0, 1'b0};
                    end else begin
                        n_omed = {r_m0[SAMPLE_BITS-1], r_m0} + {srt_q[SAMPLE_BITS-1], srt_q};
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= LEN_W'(LEN_INIT);
            r_fill   <= '0;
            r_ptr    <= '0;
            r_emit   <= 1'b0;
            r_stop   <= 1'b0;
            r_found  <= 1'b0;
            r_dval   <= 1'b0;
            r_ra     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_fill   <= n_fill;
            r_ptr    <= n_ptr;
            r_emit   <= n_emit;
            r_stop   <= n_stop;
            r_found  <= n_found;
            r_dval   <= n_dval;
            r_ra     <= n_ra;
            r_ovalid <= n_ovalid;
        end
        r_samp <= n_samp;
        r_didx <= n_didx;
        r_m0   <= n_m0;
        r_omed <= n_omed;
    end

    // samples in arrival order
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_wa),
        .i_wdata (in_ch.sample),
        .i_re    (hist_re),
        .i_raddr (hist_ra),
        .o_rdata (hist_q)
    );

    // samples in ascending order
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_sort_ram (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_wa),
        .i_wdata (srt_wd),
        .i_re    (srt_re),
        .i_raddr (srt_ra),
        .o_rdata (srt_q_raw)
    );
endmodule

/* dv/tb_sliding_window_median_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the sliding window median core: directed table, random stream.
module tb_sliding_window_median_core;
    import swm_pkg::*;

    localparam int WMAX           = WINDOW_MAX_DEF;
    localparam int SBITS          = SAMPLE_BITS_DEF;
    localparam int N_PHASES       = 13;
    localparam int N_RANDOM       = 1225;
    localparam int MAX_GAP        = 12;
    // Leave plenty of margin after the worst item before a length write.
    localparam int SETTLE_CYCLES  = 4 * WMAX + 20;
    localparam int CYCLE_LIMIT    = 1_000_000;
    // One long output stall, armed after this many medians, lets the core back up.
    localparam int HOLD_AT_MEDIAN = 40;
    localparam int LONG_HOLD      = 400;
    localparam int PRINT_CAP      = 60;

    typedef logic signed [SBITS-1:0] t_sample;
    typedef logic signed [SBITS:0]   t_median;
    typedef logic [CFG_BITS-1:0]     t_wlen;

    localparam t_sample SMAX    = 16'sh7FFF;
    localparam t_sample SMIN    = 16'sh8000;
    localparam t_median MED_MAX = 17'sh0FFFE;
    localparam t_median MED_MIN = 17'sh10000;
    localparam t_median MED_M1  = 17'sh1FFFF;

    // One directed request; known marks rows whose median is typed in here.
    typedef struct packed {
        t_sample smp;
        logic    restart;
        logic    known;
        t_median med;
    } t_sample_row;

    logic i_clk;
    logic i_rst_n;

    swm_in_if  #(.SAMPLE_BITS(SBITS)) in_ch ();
    swm_out_if #(.SAMPLE_BITS(SBITS)) out_ch ();
    swm_cfg_if                        cfg_ch ();

    sliding_window_median_core #(
        .WINDOW_MAX  (WMAX),
        .SAMPLE_BITS (SBITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Median predictor: window in arrival order plus a sorted copy.
    // ------------------------------------------------------------------
    t_wlen       win_len;
    t_sample     hist_mem [WMAX];
    t_sample     sort_mem [WMAX];
    int unsigned held_cnt;
    int unsigned oldest_slot;

    t_median     median_q [$];
    int          mismatches;
    int          rx_count;
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_done;
    longint      cycles;

    // Length 0 acts as 1, anything above WMAX clamps.
    function automatic int unsigned eff_len();
        if (win_len == '0) begin
            return 1;
        end
        if (int'(win_len) > WMAX) begin
            return WMAX;
        end
        return int'(win_len);
    endfunction

    // Insertion into the first count sorted entries.
    function automatic void sort_insert(input int unsigned count, input t_sample v);
        int unsigned i;
        i = count;
        while (i > 0 && sort_mem[i-1] > v) begin
            sort_mem[i] = sort_mem[i-1];
            i--;
        end
        sort_mem[i] = v;
    endfunction

    // Advances the predictor by one sample; returns 1 when a median comes out.
    function automatic bit median_step(input t_sample smp, input logic restart,
                                       output t_median med);
        int unsigned len;
        int unsigned slot;
        int unsigned i;
        int unsigned j;
        t_sample     leaving;
        bit          done;
        med  = '0;
        len  = eff_len();
        done = 1'b0;
        if (restart) begin
            held_cnt    = 0;
            oldest_slot = 0;
        end
        if (held_cnt >= len) begin
            slot    = oldest_slot % len;
            leaving = hist_mem[slot];
            // only one copy of a repeated value leaves
            for (i = 0; i < len; i++) begin
                if (!done && sort_mem[i] == leaving) begin
                    for (j = i; j + 1 < len; j++) begin
                        sort_mem[j] = sort_mem[j+1];
                    end
                    done = 1'b1;
                end
            end
            sort_insert(len - 1, smp);
            hist_mem[slot] = smp;
            oldest_slot    = (slot + 1) % len;
            held_cnt       = len;
        end else begin
            hist_mem[held_cnt] = smp;
            sort_insert(held_cnt, smp);
            held_cnt++;
            oldest_slot = 0;
        end
        if (held_cnt < len) begin
            return 1'b0;
        end
        // odd length: both picks are the middle entry, so the sum is 2x
        med = {sort_mem[(len-1)/2][SBITS-1], sort_mem[(len-1)/2]}
            + {sort_mem[len/2][SBITS-1], sort_mem[len/2]};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Random sample: extremes, a narrow band full of repeats, or anything.
    function automatic t_sample draw_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return SMAX;
                    1:       return SMIN;
                    2:       return '0;
                    3:       return '1;
                    default: return t_sample'(1);
                endcase
            end
            1, 2, 3: return t_sample'($urandom_range(0, 16)) - t_sample'(8);
            default: return t_sample'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sample request driver. valid stays up across back-to-back requests;
    // it only drops when a gap is drawn.
    // ------------------------------------------------------------------
    task automatic offer_sample(input t_sample smp, input logic restart,
                                input logic known, input t_median known_med);
        int      gap;
        t_median med;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) begin
            tx_steady = !tx_steady;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= smp;
        in_ch.restart <= restart;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        // request taken at this edge: predict now, medians come out in order
        if (median_step(smp, restart, med)) begin
            median_q = {median_q, (known ? known_med : med)};
        end
    endtask

    // Length writes only with the core idle: nothing outstanding, and long
    // enough for a filling-phase request (which gives no median) to finish.
    task automatic write_window_length(input t_wlen len);
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        win_len     = len;
        held_cnt    = 0;
        oldest_slot = 0;
    endtask

    // Directed rows, run at the reset length of 4.
    t_sample_row dir_rows [25] = '{
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b0, '0},
        '{SMAX, 1'b0, 1'b1, MED_MAX},       // full window of max values
        '{SMIN, 1'b1, 1'b0, '0},            // restart on a full window
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMIN, 1'b0, 1'b0, '0},
        '{SMIN, 1'b0, 1'b1, MED_MIN},       // full window of min values
        '{SMAX, 1'b0, 1'b1, MED_MIN},
        '{SMAX, 1'b0, 1'b1, MED_M1},        // two max, two min
        '{16'sd5, 1'b1, 1'b0, '0},
        '{16'sd5, 1'b0, 1'b0, '0},
        '{16'sd5, 1'b0, 1'b0, '0},
        '{16'sd5, 1'b0, 1'b1, 17'sd10},
        '{16'sd7, 1'b0, 1'b1, 17'sd10},     // one of four equal values leaves
        '{16'sd7, 1'b0, 1'b1, 17'sd12},
        '{16'sd7, 1'b0, 1'b1, 17'sd14},
        '{-16'sd1, 1'b0, 1'b0, '0},
        '{16'sh5555, 1'b0, 1'b0, '0},
        '{16'shAAAA, 1'b0, 1'b0, '0},
        '{16'sd100, 1'b1, 1'b0, '0},
        '{16'sd200, 1'b1, 1'b0, '0},        // restart while still filling
        '{16'sd300, 1'b0, 1'b0, '0},
        '{16'sd400, 1'b0, 1'b0, '0},
        '{16'sd500, 1'b0, 1'b1, 17'sd700}
    };

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Median sink: random ready gaps, one long stall, in-order compare.
    // ------------------------------------------------------------------
    initial begin : median_sink
        int      gap;
        t_median want;
        out_ch.ready <= 1'b0;
        rx_count  = 0;
        rx_steady = 1'b0;
        hold_done = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 49) == 0) begin
                rx_steady = !rx_steady;
            end
            if (!hold_done && rx_count == HOLD_AT_MEDIAN) begin
                // sender keeps offering; input side must back up and stall
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            rx_count++;
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("median %0d with nothing outstanding",
                                          out_ch.median_doubled));
            end else begin
                want = median_q.pop_front();
                if (out_ch.median_doubled !== want) begin
                    report_mismatch($sformatf("median_doubled expected %0d got %0d",
                                              want, out_ch.median_doubled));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases, each opened by
    // a length write. Fixed lengths cover 0 (acts as 1), 1, 127 and 65
    // (clamp), even and odd lengths, and the full 64.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_wlen       phase_len [N_PHASES];
        int          per_phase;
        int unsigned len;
        t_sample     smp;
        logic        restart;

        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.sample   <= '0;
        in_ch.restart  <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        mismatches  = 0;
        tx_steady   = 1'b0;
        win_len     = t_wlen'(LEN_RESET);
        held_cnt    = 0;
        oldest_slot = 0;

        phase_len = '{7'd0, 7'd1, 7'd127, 7'd2, 7'd3, 7'd64, 7'd65, 7'd4, 7'd5, 7'd8,
                      7'd0, 7'd0, 7'd0};
        phase_len[10] = t_wlen'($urandom_range(1, 16));
        phase_len[11] = t_wlen'($urandom_range(1, 16));
        phase_len[12] = t_wlen'($urandom_range(0, 127));
        per_phase = N_RANDOM / N_PHASES;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            offer_sample(dir_rows[r].smp, dir_rows[r].restart,
                         dir_rows[r].known, dir_rows[r].med);
        end
        in_ch.valid <= 1'b0;

        foreach (phase_len[p]) begin
            write_window_length(phase_len[p]);
            len = eff_len();
            for (int k = 0; k < per_phase; k++) begin
                smp = draw_sample();
                // restarts are rare enough that long windows still fill
                restart = ($urandom_range(0, 4 * len + 20) == 0);
                offer_sample(smp, restart, 1'b0, '0);
            end
            in_ch.valid <= 1'b0;
        end

        while (median_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
